/* hdl/fru_dec_pkg.sv */
// Shared types, constants and the BCD-plus character table for the FRU area
// type/length field decoder. No dependencies; imported by every module.

package fru_dec_pkg;

  // Size limits of the decoder.
  localparam int AREA_BYTES = 256;
  localparam int MAX_FIELDS = 8;
  localparam int AREA_UNITS = AREA_BYTES / 8;

  // Byte position and area length must hold the area size and any start offset.
  localparam int POS_W = ($clog2(AREA_BYTES) + 1 > 9) ? $clog2(AREA_BYTES) + 1 : 9;
  localparam int CNT_W = 4;
  localparam int REM_W = 6;

  localparam int BYTE_W   = 8;
  localparam int EVENT_W  = 3;
  localparam int INDEX_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_TOTAL = 1'd1;

  localparam logic [BYTE_W-1:0] FIELD_START_RESET = 8'd3;
  localparam logic [CNT_W-1:0]  FIELD_TOTAL_RESET = 4'd2;

  // Field types from bits 7..6 of a type/length byte.
  localparam logic [1:0] KIND_BINARY = 2'd0;
  localparam logic [1:0] KIND_BCD    = 2'd1;
  localparam logic [1:0] KIND_PACKED = 2'd2;
  localparam logic [1:0] KIND_TEXT   = 2'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_CHAR    = 3'd1,
    EV_SKIP    = 3'd2,
    EV_BADLEN  = 3'd3,
    EV_OVERRUN = 3'd4
  } event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] field_start;
    logic [CNT_W-1:0]  field_total;
  } cfg_t;

  typedef struct packed {
    event_t             ev;
    logic [BYTE_W-1:0]  char_code;
    logic [INDEX_W-1:0] field_index;
    logic               last_in_field;
    logic               last_of_area;
  } result_t;

  function automatic logic [BYTE_W-1:0] bcd_plus_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] ch;
    case (nib)
      4'hA:    ch = 8'h20;  // space
      4'hB:    ch = 8'h2D;  // '-'
      4'hC:    ch = 8'h2E;  // '.'
      4'hD:    ch = 8'h3A;  // ':'
      4'hE:    ch = 8'h2C;  // ','
      4'hF:    ch = 8'h5F;  // '_'
      default: ch = 8'h30 + {4'h0, nib};
    endcase
    return ch;
  endfunction

endpackage

/* hdl/fru_dec_step.sv */
// Parse state registers and the per-byte decode logic of the FRU field decoder.
// Depends on fru_dec_pkg.

module fru_dec_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [fru_dec_pkg::BYTE_W-1:0] byte_in,
  input  logic                        begin_in,
  input  fru_dec_pkg::cfg_t           cfg,
  output fru_dec_pkg::result_t        res
);
  import fru_dec_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] area_length, area_length_next;
  logic [CNT_W-1:0] fields_done, fields_done_next;
  logic [REM_W-1:0] field_remaining, field_remaining_next;
  logic [1:0]       field_kind, field_kind_next;
  logic             parse_active, parse_active_next;

  // Current state as seen by this byte, after a possible restart.
  logic [POS_W-1:0] pos, alen;
  logic [CNT_W-1:0] done, done_inc, total;
  logic [REM_W-1:0] rem;
  logic [1:0]       kind;
  logic             active;
  logic [BYTE_W-1:0] start;
  logic [10:0]      len_bytes;
  logic [1:0]       tl_kind;
  logic [REM_W-1:0] tl_len;
  logic             overrun;

  always_comb begin
    pos    = begin_in ? '0 : byte_position;
    alen   = begin_in ? '0 : area_length;
    done   = begin_in ? '0 : fields_done;
    rem    = begin_in ? '0 : field_remaining;
    kind   = begin_in ? '0 : field_kind;
    active = begin_in || parse_active;

    done_inc  = done + 1'b1;
    total     = (cfg.field_total > CNT_W'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS)
                                                       : cfg.field_total;
    start     = (cfg.field_start < 8'd2) ? 8'd2 : cfg.field_start;
    len_bytes = {byte_in, 3'b000};
    tl_kind   = byte_in[7:6];
    tl_len    = byte_in[REM_W-1:0];
    overrun   = ((POS_W+1)'(pos) + (POS_W+1)'(tl_len)) >= (POS_W+1)'(alen);

    byte_position_next   = byte_position;
    area_length_next     = area_length;
    fields_done_next     = fields_done;
    field_remaining_next = field_remaining;
    field_kind_next      = field_kind;
    parse_active_next    = parse_active;
    res = '{ev: EV_NONE, char_code: '0, field_index: '0,
            last_in_field: 1'b0, last_of_area: 1'b0};

    if (step_en) begin
      byte_position_next   = pos;
      area_length_next     = alen;
      fields_done_next     = done;
      field_remaining_next = rem;
      field_kind_next      = kind;
      parse_active_next    = active;

      if (active) begin
        byte_position_next = (pos == POS_MAX) ? pos : pos + 1'b1;
        if (pos == '0) begin
          // Byte 0 carries the format version and is not checked.
        end else if (pos == POS_W'(1)) begin
          area_length_next = POS_W'(len_bytes);
          if (len_bytes == '0 || 32'(byte_in) > AREA_UNITS) begin
            parse_active_next = 1'b0;
            res.ev           = EV_BADLEN;
            res.last_of_area = 1'b1;
          end else if (total == '0) begin
            parse_active_next = 1'b0;
          end
        end else if (pos < POS_W'(start)) begin
          // Header bytes ahead of the first field.
        end else if (rem == '0) begin
          if (done >= total) begin
            parse_active_next = 1'b0;
          end else if (overrun) begin
            parse_active_next = 1'b0;
            res.ev           = EV_OVERRUN;
            res.field_index  = done[INDEX_W-1:0];
            res.last_of_area = 1'b1;
          end else begin
            field_kind_next      = tl_kind;
            field_remaining_next = tl_len;
            if (tl_len == '0 || tl_kind == KIND_BINARY || tl_kind == KIND_PACKED) begin
              fields_done_next  = done_inc;
              res.ev            = EV_SKIP;
              res.field_index   = done[INDEX_W-1:0];
              res.last_in_field = 1'b1;
              if (done_inc >= total) begin
                parse_active_next = 1'b0;
                res.last_of_area  = 1'b1;
              end
            end
          end
        end else begin
          field_remaining_next = rem - 1'b1;
          // Data of binary and packed fields passes silently.
          if (kind == KIND_BCD || kind == KIND_TEXT) begin
            res.ev          = EV_CHAR;
            res.char_code   = (kind == KIND_BCD) ? bcd_plus_char(byte_in[3:0]) : byte_in;
            res.field_index = done[INDEX_W-1:0];
            if (rem == REM_W'(1)) begin
              res.last_in_field = 1'b1;
              fields_done_next  = done_inc;
              if (done_inc >= total) begin
                parse_active_next = 1'b0;
                res.last_of_area  = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      area_length     <= '0;
      fields_done     <= '0;
      field_remaining <= '0;
      field_kind      <= '0;
      parse_active    <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      area_length     <= area_length_next;
      fields_done     <= fields_done_next;
      field_remaining <= field_remaining_next;
      field_kind      <= field_kind_next;
      parse_active    <= parse_active_next;
    end
  end

endmodule

/* hdl/fru_area_field_decoder.sv */
// Top level of the FRU area type/length field decoder: configuration registers,
// input register, output register and the decode stage. Depends on fru_dec_pkg
// and fru_dec_step.
//
// Usage:
//   Bytes of one FRU inventory area arrive on the input channel (area_byte,
//   area_begin with in_valid/in_stall); area_begin marks byte 0 and restarts
//   parsing at any time. Every accepted byte yields exactly one transaction on
//   the output channel (out_valid/out_stall) carrying event_res, char_code,
//   field_index, last_in_field and last_of_area.
//   The byte is captured in the input register, and the decode stage writes
//   its result into the output register when it advances. Throughput is one
//   byte per cycle while the receiver does not stall; the parse state is updated
//   once per byte in the decode stage, which is the only loop.
//   When the receiver stalls, the result is held in the output register and the
//   next byte waits in the input register; in_stall rises only when both are
//   full. The user must write the configuration port (cfg_write, cfg_index,
//   cfg_data) only while no transaction is in flight; no logic enforces it.
//   Synchronous reset empties both registers, returns the parser to idle and
//   loads field_start = 3 and field_total = 2.

module fru_area_field_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      area_byte,
  input  logic                            area_begin,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      event_res,
  output logic [7:0]                      char_code,
  output logic [2:0]                      field_index,
  output logic                            last_in_field,
  output logic                            last_of_area,
  input  logic                            cfg_write,
  input  logic [fru_dec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import fru_dec_pkg::*;

  cfg_t              cfg;
  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_begin;
  logic              advance;
  logic              accept;
  result_t           step_res;
  result_t           out_res;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_start <= FIELD_START_RESET;
      cfg.field_total <= FIELD_TOTAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIELD_START: cfg.field_start <= cfg_data;
        REG_FIELD_TOTAL: cfg.field_total <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte  <= area_byte;
      hold_begin <= area_begin;
    end
    if (advance) begin
      out_res <= step_res;
    end
  end

  fru_dec_step u_step (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .byte_in  (hold_byte),
    .begin_in (hold_begin),
    .cfg      (cfg),
    .res      (step_res)
  );

  assign event_res     = out_res.ev;
  assign char_code     = out_res.char_code;
  assign field_index   = out_res.field_index;
  assign last_in_field = out_res.last_in_field;
  assign last_of_area  = out_res.last_of_area;

endmodule

/* hdl/fru_dec_checker.sv */
// Port-level checks for the FRU area field decoder, bound to the top level.
// Depends on fru_dec_pkg and fru_area_field_decoder.

module fru_dec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_res,
  input logic [7:0] char_code,
  input logic [2:0] field_index,
  input logic       last_in_field,
  input logic       last_of_area
);
  import fru_dec_pkg::*;

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(char_code)
      && $stable(field_index) && $stable(last_in_field) && $stable(last_of_area))
    else $error("output payload changed while stalled");

  // A new result rises only after the input transaction that caused it.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transaction");

  // A character code is carried only by a character event.
  a_char_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_CHAR |-> char_code == '0)
    else $error("char_code set on a non-character event");

  // Aborting events end the area and belong to no field ending.
  a_abort: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_BADLEN || event_res == EV_OVERRUN)
      |-> last_of_area && !last_in_field)
    else $error("abort event without area end");

  // Event none carries no flags.
  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_NONE |-> !last_in_field && !last_of_area
      && field_index == '0)
    else $error("flags set on an empty event");

endmodule

bind fru_area_field_decoder fru_dec_checker u_fru_dec_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_res     (event_res),
  .char_code     (char_code),
  .field_index   (field_index),
  .last_in_field (last_in_field),
  .last_of_area  (last_of_area)
);
